>>> hw/rtl/frame_store_max_normalize_rgba_defines.svh
// ---------------------------------------------------------------------------
// Frame store assertion macros
// Concurrent assertion helpers clocked on clk, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef FRAME_STORE_MAX_NORMALIZE_RGBA_DEFINES_SVH
`define FRAME_STORE_MAX_NORMALIZE_RGBA_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk while rst is low.
`define FSMN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define FSMN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSMN_ASSERT(label, prop, msg)
`define FSMN_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> hw/rtl/fsmn_pkg.sv
// ---------------------------------------------------------------------------
// Frame store normalizer package
// Shared constants, register indexes, command codes and sequencer states.
// ---------------------------------------------------------------------------
package fsmn_pkg;

  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_CHANNEL_BITS = 16;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BYTE_ORDER   = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] RESET_WIDTH  = 9'd256;
  localparam logic [CFG_DATA_BITS-1:0] RESET_HEIGHT = 9'd256;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_MAXIMA = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  localparam logic [7:0] FULL_SCALE = 8'hFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FETCH,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

>>> hw/rtl/frame_store_max_normalize_rgba.sv
// After reset a clearing pass zeroes the store, with s_tready low.
// A read outside the frame goes straight to the finish state that loads the output register; one
// inside is fetched first, and one shared restoring divider then makes one quotient bit per
// cycle, 8 per channel, skipped for a zero channel maximum or a value at or above it.
// A maxima walk makes one store read per cycle over the frame, then latches the maxima.
// rst is synchronous and active high; it restores the registers and restarts the clear.
// ---------------------------------------------------------------------------
// Frame store with per-channel maximum normalization
// Stores RGB pixels, finds channel maxima and returns pixels scaled to RGBA bytes.
// ---------------------------------------------------------------------------
`include "frame_store_max_normalize_rgba_defines.svh"

module frame_store_max_normalize_rgba
  import fsmn_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // x_pos[7:0], y_pos[15:8], red_in[31:16], green_in[47:32], blue_in[63:48]
  input  logic [63:0]              s_tdata,
  // kind[1:0]
  input  logic [1:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // packed_pixel[31:0]
  output logic [31:0]              m_tdata,
  // in_range[0]
  output logic [0:0]               m_tuser,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB    = CHANNEL_BITS;
  localparam int PW    = 3 * CB;

  state_t state, state_next;

  logic [CFG_DATA_BITS-1:0] image_width, image_height;
  logic                     byte_order;
  logic [8:0]               cols_use, rows_use;

  logic [1:0]  kind;
  logic [7:0]  x_pos, y_pos;
  logic [31:0] red32, green32, blue32;
  logic        accept, in_frame;
  logic [AW-1:0] pix_addr;

  logic [PW-1:0] mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [PW-1:0] mem_wdata, mem_rdata;

  logic [AW-1:0] clr_addr, walk_addr, row_base;
  logic [8:0]    col, row;
  logic          rd_valid;
  logic [CB-1:0] run_r, run_g, run_b, run_r_next, run_g_next, run_b_next;
  logic [CB-1:0] rd_r, rd_g, rd_b;
  logic [CB-1:0] max_r, max_g, max_b;

  logic [PW-1:0]   pix;
  logic [1:0]      chan;
  logic [2:0]      bit_cnt;
  logic [CB-1:0]   rem, sel_v, sel_m;
  logic [7:0]      low, quo;
  logic [CB+7:0]   prod;
  logic [CB:0]     trial, diff;
  logic            ge;
  logic [7:0]      chan_byte [3];
  logic            rd_inside;
  logic [31:0]     packed_word;
  logic            walk_last_col, walk_last_row;

  assign kind    = s_tuser;
  assign x_pos   = s_tdata[7:0];
  assign y_pos   = s_tdata[15:8];
  assign red32   = {16'b0, s_tdata[31:16]};
  assign green32 = {16'b0, s_tdata[47:32]};
  assign blue32  = {16'b0, s_tdata[63:48]};

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign cols_use = ({23'b0, image_width} > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : image_width;
  assign rows_use = ({23'b0, image_height} > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : image_height;
  assign in_frame = ({1'b0, x_pos} < cols_use) && ({1'b0, y_pos} < rows_use);
  assign pix_addr = AW'(int'(y_pos) * MAX_WIDTH + int'(x_pos));

  assign walk_last_col = (col == cols_use - 9'd1);
  assign walk_last_row = (row == rows_use - 9'd1);

  assign rd_r = mem_rdata[CB-1:0];
  assign rd_g = mem_rdata[2*CB-1:CB];
  assign rd_b = mem_rdata[3*CB-1:2*CB];

  assign run_r_next = (rd_valid && (rd_r > run_r)) ? rd_r : run_r;
  assign run_g_next = (rd_valid && (rd_g > run_g)) ? rd_g : run_g;
  assign run_b_next = (rd_valid && (rd_b > run_b)) ? rd_b : run_b;

  always_comb begin
    case (chan)
      CHAN_RED: begin
        sel_v = pix[CB-1:0];
        sel_m = max_r;
      end
      CHAN_GREEN: begin
        sel_v = pix[2*CB-1:CB];
        sel_m = max_g;
      end
      CHAN_BLUE: begin
        sel_v = pix[3*CB-1:2*CB];
        sel_m = max_b;
      end
      default: begin
        sel_v = '0;
        sel_m = '0;
      end
    endcase
  end

  // value*255 as (value << 8) - value; one restoring step per cycle after that.
  assign prod  = {sel_v, 8'b0} - {8'b0, sel_v};
  assign trial = {rem, low[7]};
  assign ge    = (trial >= {1'b0, sel_m});
  assign diff  = trial - {1'b0, sel_m};

  assign packed_word = byte_order ?
      {chan_byte[0], chan_byte[1], chan_byte[2], FULL_SCALE} :
      {FULL_SCALE, chan_byte[2], chan_byte[1], chan_byte[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      byte_order   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        REG_BYTE_ORDER:   byte_order   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = pix_addr;
    mem_wdata  = {blue32[CB-1:0], green32[CB-1:0], red32[CB-1:0]};
    mem_raddr  = pix_addr;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_WRITE: mem_we = in_frame;
            KIND_MAXIMA: begin
              if (cols_use != 9'd0 && rows_use != 9'd0) begin
                state_next = ST_WALK;
              end
            end
            KIND_READ: state_next = in_frame ? ST_FETCH : ST_FINISH;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        mem_raddr = walk_addr;
        if (walk_last_col && walk_last_row) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_IDLE;
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD: begin
        if (sel_m != '0 && sel_v < sel_m) begin
          state_next = ST_DIV;
        end else if (chan == CHAN_BLUE) begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (bit_cnt == 3'd7) begin
          state_next = (chan == CHAN_BLUE) ? ST_FINISH : ST_LOAD;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      rd_valid <= 1'b0;
      max_r    <= '0;
      max_g    <= '0;
      max_b    <= '0;
    end else begin
      rd_valid <= (state == ST_WALK);
      if (rd_valid) begin
        run_r <= run_r_next;
        run_g <= run_g_next;
        run_b <= run_b_next;
      end
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        ST_IDLE: begin
          if (accept && kind == KIND_MAXIMA) begin
            col       <= '0;
            row       <= '0;
            walk_addr <= '0;
            row_base  <= '0;
            run_r     <= '0;
            run_g     <= '0;
            run_b     <= '0;
            if (cols_use == 9'd0 || rows_use == 9'd0) begin
              max_r <= '0;
              max_g <= '0;
              max_b <= '0;
            end
          end
          if (accept && kind == KIND_READ) begin
            rd_inside <= in_frame;
            chan      <= CHAN_RED;
          end
        end
        ST_WALK: begin
          if (walk_last_col) begin
            col       <= '0;
            row       <= row + 9'd1;
            row_base  <= row_base + AW'(MAX_WIDTH);
            walk_addr <= row_base + AW'(MAX_WIDTH);
          end else begin
            col       <= col + 9'd1;
            walk_addr <= walk_addr + AW'(1);
          end
        end
        ST_DRAIN: begin
          max_r <= run_r_next;
          max_g <= run_g_next;
          max_b <= run_b_next;
        end
        ST_FETCH: pix <= mem_rdata;
        ST_LOAD: begin
          rem     <= prod[CB+7:8];
          low     <= prod[7:0];
          quo     <= '0;
          bit_cnt <= '0;
          if (sel_m == '0) begin
            chan_byte[chan] <= 8'd0;
            chan            <= chan + 2'd1;
          end else if (sel_v >= sel_m) begin
            chan_byte[chan] <= FULL_SCALE;
            chan            <= chan + 2'd1;
          end
        end
        ST_DIV: begin
          rem     <= ge ? diff[CB-1:0] : trial[CB-1:0];
          low     <= {low[6:0], 1'b0};
          quo     <= {quo[6:0], ge};
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            chan_byte[chan] <= {quo[6:0], ge};
            chan            <= chan + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= rd_inside ? packed_word : 32'd0;
      m_tuser  <= rd_inside;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `FSMN_ASSERT(a_rem_below_max, (state == ST_DIV) |-> (rem < sel_m), "remainder not below divisor")
  `FSMN_ASSERT(a_out_of_range_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0), "out-of-range item carries data")
  `FSMN_ASSERT(a_walk_addr, (state == ST_WALK) |-> (walk_addr == row_base + AW'(col)), "walk address out of step")
  `FSMN_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == ST_CLEAR && !m_tvalid), "reset does not restart the clear")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame store normalizer testbench
// Drives write, maxima and read items into the frame store over the input
// stream and predicts every packed pixel from its own copy of the store, the
// channel maxima and the frame registers. Directed items cover the frame
// corners, the size limits, a zero maximum and saturation; random phases
// then vary the frame size, the byte order and the idling on both sides.
// ---------------------------------------------------------------------------
module tb;
  import fsmn_pkg::*;

  localparam logic [1:0]              KIND_SPARE = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE  = 2'd3;

  typedef struct packed {
    logic [15:0] blue_in;
    logic [15:0] green_in;
    logic [15:0] red_in;
    logic [7:0]  y_pos;
    logic [7:0]  x_pos;
  } pixel_cmd_t;

  typedef struct packed {
    logic [31:0] packed_pixel;
    logic        in_range;
  } read_result_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  // x_pos[7:0], y_pos[15:8], red_in[31:16], green_in[47:32], blue_in[63:48]
  logic [63:0]              s_tdata;
  // kind[1:0]
  logic [1:0]               s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  // packed_pixel[31:0]
  logic [31:0]              m_tdata;
  // in_range[0]
  logic [0:0]               m_tuser;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  logic [15:0] pix_red   [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  logic [15:0] pix_green [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  logic [15:0] pix_blue  [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  logic [15:0] peak_red;
  logic [15:0] peak_green;
  logic [15:0] peak_blue;
  logic [8:0]  cfg_cols;
  logic [8:0]  cfg_rows;
  logic        cfg_big_endian;

  read_result_t expected_reads[$];
  read_result_t oldest_read;
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           tx_gap_pct = 0;
  int           rx_stall_pct = 0;
  int           stall_left = 0;

  frame_store_max_normalize_rgba i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int frame_cols();
    return (cfg_cols > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_cols;
  endfunction

  function automatic int frame_rows();
    return (cfg_rows > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_rows;
  endfunction

  function automatic logic [7:0] to_byte(input logic [15:0] level, input logic [15:0] peak);
    logic [23:0] quotient;
    if (peak == 16'd0) return 8'd0;
    quotient = ({8'd0, level} * {16'd0, FULL_SCALE}) / {8'd0, peak};
    return (quotient > {16'd0, FULL_SCALE}) ? FULL_SCALE : quotient[7:0];
  endfunction

  function automatic logic [7:0] pick_coord(input int span);
    if (span > 0 && $urandom_range(0, 99) < 85) return 8'($urandom_range(0, span - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [8:0] extreme_size();
    case ($urandom_range(0, 4))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'($urandom_range(257, 510));
      default: return 9'd511;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic predict_command(input logic [1:0] kind, input pixel_cmd_t cmd);
    int           cols;
    int           rows;
    int           addr;
    int           row;
    int           col;
    logic         hit;
    logic [7:0]   red_b;
    logic [7:0]   green_b;
    logic [7:0]   blue_b;
    read_result_t res;
    cols = frame_cols();
    rows = frame_rows();
    hit = (cmd.x_pos < cols) && (cmd.y_pos < rows);
    addr = cmd.y_pos * DEF_MAX_WIDTH + cmd.x_pos;
    case (kind)
      KIND_WRITE: begin
        if (hit) begin
          pix_red[addr] = cmd.red_in;
          pix_green[addr] = cmd.green_in;
          pix_blue[addr] = cmd.blue_in;
        end
      end
      KIND_MAXIMA: begin
        peak_red = '0;
        peak_green = '0;
        peak_blue = '0;
        for (row = 0; row < rows; row++) begin
          for (col = 0; col < cols; col++) begin
            addr = row * DEF_MAX_WIDTH + col;
            if (pix_red[addr] > peak_red) peak_red = pix_red[addr];
            if (pix_green[addr] > peak_green) peak_green = pix_green[addr];
            if (pix_blue[addr] > peak_blue) peak_blue = pix_blue[addr];
          end
        end
      end
      KIND_READ: begin
        res.in_range = hit;
        res.packed_pixel = '0;
        if (hit) begin
          red_b = to_byte(pix_red[addr], peak_red);
          green_b = to_byte(pix_green[addr], peak_green);
          blue_b = to_byte(pix_blue[addr], peak_blue);
          if (cfg_big_endian) res.packed_pixel = {red_b, green_b, blue_b, FULL_SCALE};
          else res.packed_pixel = {FULL_SCALE, blue_b, green_b, red_b};
        end
        expected_reads.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic send_command(input logic [1:0] kind, input logic [7:0] x, input logic [7:0] y,
                              input logic [15:0] red, input logic [15:0] green,
                              input logic [15:0] blue);
    pixel_cmd_t cmd;
    cmd = '{blue_in: blue, green_in: green, red_in: red, y_pos: y, x_pos: x};
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= cmd;
    s_tuser <= kind;
    do @(posedge clk); while (!s_tready);
    predict_command(kind, cmd);
    if (kind != KIND_SPARE) items_sent++;
  endtask

  // A read item follows everything already sent, so its result marks the block idle.
  task automatic settle();
    send_command(KIND_READ, pick_coord(frame_cols()), pick_coord(frame_rows()),
                 pick_level(), pick_level(), pick_level());
    s_tvalid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH: cfg_cols = value;
      REG_IMAGE_HEIGHT: cfg_rows = value;
      REG_BYTE_ORDER: cfg_big_endian = value[0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [8:0] cols, input logic [8:0] rows,
                           input logic [8:0] order);
    settle();
    write_reg(REG_IMAGE_WIDTH, cols);
    write_reg(REG_IMAGE_HEIGHT, rows);
    write_reg(REG_BYTE_ORDER, order);
    write_reg(REG_SPARE, 9'($urandom_range(0, 511)));
    cfg_we <= 1'b0;
  endtask

  task automatic run_frame_phase(input int n_items);
    int         walk_at;
    int         idx;
    int         pick;
    logic [1:0] kind;
    walk_at = n_items / 3 + $urandom_range(0, n_items / 3);
    for (idx = 0; idx < n_items; idx++) begin
      pick = $urandom_range(0, 99);
      if (idx == walk_at || pick < 2) kind = KIND_MAXIMA;
      else if (pick < 6) kind = KIND_SPARE;
      else if (idx < walk_at) kind = (pick < 70) ? KIND_WRITE : KIND_READ;
      else kind = (pick < 40) ? KIND_WRITE : KIND_READ;
      send_command(kind, pick_coord(frame_cols()), pick_coord(frame_rows()),
                   pick_level(), pick_level(), pick_level());
    end
  endtask

  task automatic test_reset_defaults();
    send_command(KIND_READ, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_WRITE, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(KIND_WRITE, 8'd255, 8'd255, 16'h0001, 16'h8000, 16'h0000);
    send_command(KIND_WRITE, 8'd255, 8'd0, 16'h1234, 16'h0000, 16'hFFFF);
    send_command(KIND_WRITE, 8'd0, 8'd255, 16'h0000, 16'h0001, 16'h7FFF);
    send_command(KIND_SPARE, 8'd128, 8'd64, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_command(KIND_MAXIMA, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_READ, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_READ, 8'd255, 8'd255, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_READ, 8'd255, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_READ, 8'd0, 8'd255, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_READ, 8'd1, 8'd1, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_frame_edges();
    set_frame(9'd4, 9'd2, 9'd1);
    send_command(KIND_WRITE, 8'd0, 8'd0, 16'd100, 16'hFFFF, 16'h0000);
    send_command(KIND_WRITE, 8'd3, 8'd1, 16'd50, 16'd7, 16'h0000);
    send_command(KIND_WRITE, 8'd4, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(KIND_MAXIMA, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_READ, 8'd3, 8'd1, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_READ, 8'd4, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_WRITE, 8'd1, 8'd1, 16'hFFFF, 16'd3, 16'd9);
    send_command(KIND_READ, 8'd1, 8'd1, 16'h0000, 16'h0000, 16'h0000);
    set_frame(9'd0, 9'd256, 9'd0);
    send_command(KIND_WRITE, 8'd0, 8'd0, 16'h4321, 16'h4321, 16'h4321);
    send_command(KIND_READ, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_MAXIMA, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    set_frame(9'd511, 9'd1, 9'd0);
    send_command(KIND_MAXIMA, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_READ, 8'd255, 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_READ, 8'd0, 8'd1, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_frames();
    logic [8:0] cols;
    logic [8:0] rows;
    int         shape;
    while (items_sent < 1000) begin
      shape = $urandom_range(0, 7);
      cols = (shape == 0) ? extreme_size() : 9'($urandom_range(1, (shape == 1) ? 4 : 24));
      rows = (shape == 1) ? extreme_size() : 9'($urandom_range(1, (shape == 0) ? 4 : 24));
      set_frame(cols, rows, 9'($urandom_range(0, 511)));
      case ($urandom_range(0, 2))
        0: tx_gap_pct = 0;
        1: tx_gap_pct = 10;
        default: tx_gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 10;
        default: rx_stall_pct = 40;
      endcase
      run_frame_phase($urandom_range(40, 80));
    end
  endtask

  task automatic test_back_to_back();
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    set_frame(9'd16, 9'd16, 9'($urandom_range(0, 511)));
    run_frame_phase(60);
  endtask

  always @(posedge clk) begin
    if (rst || rx_stall_pct == 0) begin
      m_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected result %08h in_range %0b", m_tdata, m_tuser[0]));
      end else begin
        oldest_read = expected_reads.pop_front();
        if (m_tdata !== oldest_read.packed_pixel)
          report_mismatch($sformatf("packed_pixel %08h, expected %08h",
                                    m_tdata, oldest_read.packed_pixel));
        if (m_tuser[0] !== oldest_read.in_range)
          report_mismatch($sformatf("in_range %0b, expected %0b",
                                    m_tuser[0], oldest_read.in_range));
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= KIND_WRITE;
    cfg_we <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    for (int addr = 0; addr < DEF_MAX_WIDTH * DEF_MAX_HEIGHT; addr++) begin
      pix_red[addr] = '0;
      pix_green[addr] = '0;
      pix_blue[addr] = '0;
    end
    peak_red = '0;
    peak_green = '0;
    peak_blue = '0;
    cfg_cols = RESET_WIDTH;
    cfg_rows = RESET_HEIGHT;
    cfg_big_endian = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_frame_edges();
    test_random_frames();
    test_back_to_back();
    settle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fsmn_pkg.sv
hw/rtl/frame_store_max_normalize_rgba.sv
bench/tb.sv
